// File: design/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types for the 3x3 BGRA median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 2048;
  localparam int unsigned CHANNEL_BITS_DEF = 32;

  localparam int unsigned PORT_BITS        = 32;
  localparam int unsigned NUM_CH           = 4;
  localparam int unsigned WIDTH_REG_BITS   = 12;
  localparam int unsigned HEIGHT_REG_BITS  = 13;
  localparam int unsigned CFG_DATA_BITS    = 13;
  localparam int unsigned ROW_BITS         = 13;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [ROW_BITS-1:0]        HEIGHT_MIN   = 13'd2;
  localparam logic [ROW_BITS-1:0]        HEIGHT_LIMIT = 13'd4096;

  // bit k set: channel k takes the median; clear: centre passes through
  localparam logic [7:0] MEDIAN_LANES = 8'h77;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // load enables of the sort stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// File: design/median_3x3_bgra_filter.sv
// ----------------------------------------------------------------------------
// median_3x3_bgra_filter
// Stages from input accept: line RAM, window, three sort stages, output
// register; one pixel per cycle, stalls only on output.
// Results trail the input stream by one line plus one pixel; frame_width + 1
// drain items after the frame bring out the last line. Line RAM is read at
// accept, written as the word leaves S1. Reset clears counters, handshake
// state and config; line RAM is not cleared.
// ----------------------------------------------------------------------------
module median_3x3_bgra_filter #(
  parameter int unsigned MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned CHANNEL_BITS = mf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mf3_pkg::PORT_BITS-1:0]      blue_in_i,
  input  logic [mf3_pkg::PORT_BITS-1:0]      green_in_i,
  input  logic [mf3_pkg::PORT_BITS-1:0]      red_in_i,
  input  logic [mf3_pkg::PORT_BITS-1:0]      alpha_in_i,
  input  logic                               flush_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mf3_pkg::PORT_BITS-1:0]      blue_out_o,
  output logic [mf3_pkg::PORT_BITS-1:0]      green_out_o,
  output logic [mf3_pkg::PORT_BITS-1:0]      red_out_o,
  output logic [mf3_pkg::PORT_BITS-1:0]      alpha_out_o,
  output logic                               end_of_line_o,
  output logic                               end_of_frame_o
);
  import mf3_pkg::*;

  localparam int unsigned CB   = CHANNEL_BITS;
  localparam int unsigned PIXW = NUM_CH * CB;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned NW   = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
  localparam int unsigned RW   = ROW_BITS;

  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic eol;
    logic eof;
  } pos_t;

  // ---------------- configuration ----------------
  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;

  // ---------------- position ----------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [NW-1:0] w_cfg, w_eff, w_m1, c_ext, c1, c_inc;
  logic [RW-1:0] h_eff, h_p1, h_m1, r1, r2, orow;
  logic [CW-1:0] c2;
  logic [NW-1:0] ocol;
  logic          wrap0, draining, skip, emit_a, emit_b;
  logic          in_fire;
  logic [PIXW-1:0] pix;
  pos_t          pos;

  // ---------------- pipeline control ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic go1, go2, go3, go4, go5, go_o;
  stage_en_t lane_en;

  // ---------------- payload ----------------
  logic [PIXW-1:0]   s1_pix_q;
  logic [CW-1:0]     s1_addr_q;
  pos_t              s1_pos_q;
  logic [2*PIXW-1:0] ls_mem [MAX_WIDTH];
  logic [2*PIXW-1:0] ls_rd_q, fwd_data_q, ls_cur, ls_wdata;
  logic              fwd_q, ls_rd_en, ls_we;
  logic [8:0][PIXW-1:0] win_q;
  logic [8:0]        pad_lo, pad_hi, s2_lo_q, s2_hi_q;
  logic              row_miss, col_miss;
  logic [2:0]        n_lo, n_pad;
  logic [1:0]        s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q, out_tag_q;
  logic [NUM_CH-1:0][CB-1:0] ch_res, out_q;

  // ---------------- S0: position bookkeeping ----------------
  assign w_cfg = NW'(width_q);
  always_comb begin
    if (w_cfg < NW'(2)) begin
      w_eff = NW'(2);
    end else if (w_cfg > NW'(MAX_WIDTH)) begin
      w_eff = NW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (height_q < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (height_q > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = height_q;
    end
  end

  assign w_m1 = w_eff - NW'(1);
  assign h_p1 = h_eff + RW'(1);
  assign h_m1 = h_eff - RW'(1);

  // a stale column (width shrunk) starts the next line; past drain, new frame
  assign c_ext = NW'(col_q);
  assign wrap0 = (c_ext >= w_eff);
  assign c1    = wrap0 ? '0 : c_ext;
  assign r1    = wrap0 ? row_q + RW'(1) : row_q;
  assign r2    = (r1 > h_p1) ? '0 : r1;
  assign c2    = (r1 > h_p1) ? '0 : c1[CW-1:0];

  assign draining = (r2 >= h_eff);
  assign skip     = !draining && flush_i;
  assign emit_a   = (c2 == '0) && (r2 >= RW'(2));
  assign emit_b   = (c2 != '0) && (r2 >= RW'(1));
  assign orow     = emit_a ? r2 - RW'(2) : r2 - RW'(1);
  assign ocol     = emit_a ? w_m1 : NW'(c2) - NW'(1);
  assign c_inc    = NW'(c2) + NW'(1);

  always_comb begin
    pos.emit  = emit_a || emit_b;
    pos.top   = (orow == '0);
    pos.bot   = (orow == h_m1);
    pos.left  = (ocol == '0);
    pos.right = (ocol == w_m1);
    pos.eol   = pos.right;
    pos.eof   = pos.right && pos.bot;
  end

  assign pix = draining ? '0 : {alpha_in_i[CB-1:0], red_in_i[CB-1:0],
                                green_in_i[CB-1:0], blue_in_i[CB-1:0]};

  // ---------------- handshake chain ----------------
  assign go_o       = !out_v_q || out_ready_i;
  assign go5        = !s5_v_q || go_o;
  assign go4        = !s4_v_q || go5;
  assign go3        = !s3_v_q || go4;
  assign go2        = !s2_v_q || go3;
  assign go1        = !s1_v_q || go2;
  assign in_ready_o = go1;
  assign in_fire    = in_valid_i && go1;
  assign lane_en    = '{s3: go3, s4: go4, s5: go5};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s5_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_BITS-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_BITS-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (skip) begin
          row_q <= r2;
          col_q <= c2;
        end else if (r2 == h_p1) begin
          row_q <= '0;
          col_q <= '0;
        end else if (c_inc >= w_eff) begin
          row_q <= r2 + RW'(1);
          col_q <= '0;
        end else begin
          row_q <= r2;
          col_q <= c_inc[CW-1:0];
        end
      end
      if (go1) s1_v_q  <= in_fire && !skip;
      if (go2) s2_v_q  <= s1_v_q && s1_pos_q.emit;
      if (go3) s3_v_q  <= s2_v_q;
      if (go4) s4_v_q  <= s3_v_q;
      if (go5) s5_v_q  <= s4_v_q;
      if (go_o) out_v_q <= s5_v_q;
    end
  end

  // ---------------- S1: line RAM ----------------
  // word = {upper line, lower line}; both move down one line per write
  assign ls_rd_en = in_fire && !skip;
  assign ls_we    = s1_v_q && go2;
  assign ls_cur   = fwd_q ? fwd_data_q : ls_rd_q;
  assign ls_wdata = {ls_cur[PIXW-1:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[s1_addr_q] <= ls_wdata;
    end
    if (ls_rd_en) begin
      ls_rd_q <= ls_mem[c2];
    end
  end

  // read and write at the same column in the same cycle: take the new word
  always_ff @(posedge clk_i) begin
    if (ls_rd_en) begin
      fwd_q      <= ls_we && (s1_addr_q == c2);
      fwd_data_q <= ls_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s1_pix_q  <= pix;
      s1_addr_q <= c2;
      s1_pos_q  <= pos;
    end
  end

  // pad out-of-frame cells: 2 low + 1 high at an edge, 3 low + 2 high at a
  // corner, so the 5th of nine lands on the lower median of the real ones
  always_comb begin
    pad_lo   = '0;
    pad_hi   = '0;
    n_pad    = '0;
    row_miss = s1_pos_q.top || s1_pos_q.bot;
    col_miss = s1_pos_q.left || s1_pos_q.right;
    if (row_miss && col_miss) begin
      n_lo = 3'd3;
    end else if (row_miss || col_miss) begin
      n_lo = 3'd2;
    end else begin
      n_lo = 3'd0;
    end
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if ((dr == 0 && s1_pos_q.top) || (dr == 2 && s1_pos_q.bot) ||
            (dc == 0 && s1_pos_q.left) || (dc == 2 && s1_pos_q.right)) begin
          if (n_pad < n_lo) begin
            pad_lo[dr*3+dc] = 1'b1;
          end else begin
            pad_hi[dr*3+dc] = 1'b1;
          end
          n_pad = n_pad + 3'd1;
        end
      end
    end
  end

  // ---------------- S2: window ----------------
  // rows top to bottom, columns old to new; centre is cell 4
  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      for (int r = 0; r < 3; r++) begin
        win_q[3*r]   <= win_q[3*r+1];
        win_q[3*r+1] <= win_q[3*r+2];
      end
      win_q[2] <= ls_cur[2*PIXW-1:PIXW];
      win_q[5] <= ls_cur[PIXW-1:0];
      win_q[8] <= s1_pix_q;
    end
    if (go2) begin
      s2_lo_q  <= pad_lo;
      s2_hi_q  <= pad_hi;
      s2_tag_q <= {s1_pos_q.eof, s1_pos_q.eol};
    end
    if (go3) s3_tag_q  <= s2_tag_q;
    if (go4) s4_tag_q  <= s3_tag_q;
    if (go5) s5_tag_q  <= s4_tag_q;
    if (go_o) begin
      out_tag_q <= s5_tag_q;
      out_q     <= ch_res;
    end
  end

  // ---------------- S3..S5: per-channel lanes ----------------
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [8:0][CB-1:0] vals;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        vals[i] = win_q[i][ch*CB +: CB];
      end
    end

    if (MEDIAN_LANES[ch]) begin : g_med
      mf3_lane #(
        .CB (CB)
      ) u_lane (
        .clk_i    (clk_i),
        .en_i     (lane_en),
        .val_i    (vals),
        .pad_lo_i (s2_lo_q),
        .pad_hi_i (s2_hi_q),
        .med_o    (ch_res[ch])
      );
    end else begin : g_pass
      logic [CB-1:0] p3_q, p4_q, p5_q;

      always_ff @(posedge clk_i) begin
        if (go3) p3_q <= vals[4];
        if (go4) p4_q <= p3_q;
        if (go5) p5_q <= p4_q;
      end

      assign ch_res[ch] = p5_q;
    end
  end

  // ---------------- outputs ----------------
  assign out_valid_o    = out_v_q;
  assign blue_out_o     = PORT_BITS'(out_q[0]);
  assign green_out_o    = PORT_BITS'(out_q[1]);
  assign red_out_o      = PORT_BITS'(out_q[2]);
  assign alpha_out_o    = PORT_BITS'(out_q[3]);
  assign end_of_line_o  = out_tag_q[0];
  assign end_of_frame_o = out_tag_q[1];

endmodule

// File: design/mf3_lane.sv
// ----------------------------------------------------------------------------
// mf3_lane
// Median of nine keyed values for one channel, three register stages:
// padded keys, sorted rows, column reductions; final median-of-3 is
// combinational into the caller's output register.
// ----------------------------------------------------------------------------
module mf3_lane #(
  parameter int unsigned CB = mf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  mf3_pkg::stage_en_t    en_i,
  input  logic [8:0][CB-1:0]    val_i,
  input  logic [8:0]            pad_lo_i,
  input  logic [8:0]            pad_hi_i,
  output logic [CB-1:0]         med_o
);
  import mf3_pkg::*;

  localparam logic [CB-1:0] SIGN = {1'b1, {(CB-1){1'b0}}};

  function automatic logic [CB-1:0] to_key(input logic [CB-1:0] x);
    return x[CB-1] ? ~x : (x | SIGN);
  endfunction

  function automatic logic [CB-1:0] from_key(input logic [CB-1:0] k);
    return k[CB-1] ? (k ^ SIGN) : ~k;
  endfunction

  function automatic logic [CB-1:0] min3(input logic [CB-1:0] a, b, c);
    return (a <= b && a <= c) ? a : ((b <= c) ? b : c);
  endfunction

  function automatic logic [CB-1:0] max3(input logic [CB-1:0] a, b, c);
    return (a >= b && a >= c) ? a : ((b >= c) ? b : c);
  endfunction

  // xor of all three minus min and max leaves the middle value
  function automatic logic [CB-1:0] med3(input logic [CB-1:0] a, b, c);
    return a ^ b ^ c ^ min3(a, b, c) ^ max3(a, b, c);
  endfunction

  logic [8:0][CB-1:0] key_q;
  logic [2:0][CB-1:0] mn_q, md_q, mx_q;
  logic [CB-1:0]      lo_q, mid_q, hi_q;

  // out-of-frame cells become smallest or largest keys
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int i = 0; i < 9; i++) begin
        if (pad_lo_i[i]) begin
          key_q[i] <= '0;
        end else if (pad_hi_i[i]) begin
          key_q[i] <= '1;
        end else begin
          key_q[i] <= to_key(val_i[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int r = 0; r < 3; r++) begin
        mn_q[r] <= min3(key_q[3*r], key_q[3*r+1], key_q[3*r+2]);
        md_q[r] <= med3(key_q[3*r], key_q[3*r+1], key_q[3*r+2]);
        mx_q[r] <= max3(key_q[3*r], key_q[3*r+1], key_q[3*r+2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      lo_q  <= max3(mn_q[0], mn_q[1], mn_q[2]);
      mid_q <= med3(md_q[0], md_q[1], md_q[2]);
      hi_q  <= min3(mx_q[0], mx_q[1], mx_q[2]);
    end
  end

  assign med_o = from_key(med3(lo_q, mid_q, hi_q));

endmodule
